// ===== src/matp_pkg.sv =====
`default_nettype none

package matp_pkg;

  // number of bytes in one address string
  localparam int unsigned ADDRESS_BYTES = 6;

  // width of the completed byte counter, enough to reach ADDRESS_BYTES
  localparam int unsigned COUNT_W = $clog2(ADDRESS_BYTES + 1);

  localparam int unsigned ADDR_W = 48;

  localparam logic [COUNT_W-1:0] BYTES_FULL = COUNT_W'(ADDRESS_BYTES);

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // offsets from character code to digit value
  localparam logic [7:0] OFS_DIGIT = 8'd48;
  localparam logic [7:0] OFS_LOW   = 8'd87;
  localparam logic [7:0] OFS_UP    = 8'd55;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d.is_hex = 1'b1;
    diff     = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - OFS_DIGIT;
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      diff = c - OFS_LOW;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      diff = c - OFS_UP;
    end else begin
      d.is_hex = 1'b0;
    end
    d.value = diff[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/mac_address_text_parser.sv =====
`default_nettype none

// Hardware-address text parser. Feed the address text one ASCII character per
// transaction, with end_of_string set on the last character. Each byte is two
// hex digits (either case), high digit first; one colon may follow any
// complete byte, the last included. The transaction that carries
// end_of_string yields exactly one result: mac_address (first byte in the top
// bits) and status (0 well formed, 1 malformed, in which case mac_address is
// 0); all other characters yield nothing. The parser returns to its start
// after each string. Throughput is one character per clock cycle, save when a
// final character meets a stalled result: the character is captured in an
// input register, decoded and folded into the parse state from there, and a
// final character's result then lands in the output register and is
// offered from there. The output register is the only point where a
// stalled result holds the stream back, and only the final character of the
// next string waits on it; plain characters keep flowing while a result sits
// unclaimed.
module mac_address_text_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // character input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    char_code,
  input  wire logic                          end_of_string,
  // result output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [matp_pkg::ADDR_W-1:0]        mac_address,
  output logic                               status
);

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eos;
  logic       s1_go;      // the held character is consumed this cycle
  logic       out_free;   // output register can take a result this cycle

  // parse state
  logic                           expect_low_nibble, expect_low_nibble_next;
  logic [3:0]                     high_nibble, high_nibble_next;
  logic [matp_pkg::COUNT_W-1:0]   bytes_done, bytes_done_next;
  logic                           colon_allowed, colon_allowed_next;
  logic [matp_pkg::ADDR_W-1:0]    address_accumulator, address_accumulator_next;
  logic                           error_seen, error_seen_next;

  logic                           result_ok;
  matp_pkg::hex_digit_t           digit;

  // a result slot frees when empty or when the current result is taken
  assign out_free = !out_valid || !out_stall;
  // plain characters never need the output slot
  assign s1_go    = s1_valid && (!s1_eos || out_free);
  // the input register refills in the same cycle it drains
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= char_code;
      s1_eos  <= end_of_string;
    end
  end

  // one character step of the parser
  always_comb begin
    digit                    = matp_pkg::hex_decode(s1_char);
    expect_low_nibble_next   = expect_low_nibble;
    high_nibble_next         = high_nibble;
    bytes_done_next          = bytes_done;
    colon_allowed_next       = colon_allowed;
    address_accumulator_next = address_accumulator;
    error_seen_next          = error_seen;
    if (!error_seen) begin
      if (colon_allowed && s1_char == matp_pkg::CH_COLON) begin
        // the single colon after a byte
        colon_allowed_next = 1'b0;
      end else if (!digit.is_hex || bytes_done >= matp_pkg::BYTES_FULL) begin
        // stray character, or a digit after the last byte
        error_seen_next = 1'b1;
      end else if (!expect_low_nibble) begin
        colon_allowed_next     = 1'b0;
        high_nibble_next       = digit.value;
        expect_low_nibble_next = 1'b1;
      end else begin
        // byte complete: shift it in from the low end
        address_accumulator_next = {address_accumulator[matp_pkg::ADDR_W-9:0],
                                    high_nibble, digit.value};
        expect_low_nibble_next   = 1'b0;
        bytes_done_next          = bytes_done + matp_pkg::COUNT_W'(1);
        colon_allowed_next       = 1'b1;
      end
    end
  end

  // text is good only if it stopped after the last byte, with at most one colon behind it
  assign result_ok = !error_seen_next && !expect_low_nibble_next
                     && bytes_done_next == matp_pkg::BYTES_FULL;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_low_nibble   <= 1'b0;
      high_nibble         <= 4'd0;
      bytes_done          <= '0;
      colon_allowed       <= 1'b0;
      address_accumulator <= '0;
      error_seen          <= 1'b0;
    end else if (s1_go) begin
      if (s1_eos) begin
        // back to the start for the next string
        expect_low_nibble   <= 1'b0;
        high_nibble         <= 4'd0;
        bytes_done          <= '0;
        colon_allowed       <= 1'b0;
        address_accumulator <= '0;
        error_seen          <= 1'b0;
      end else begin
        expect_low_nibble   <= expect_low_nibble_next;
        high_nibble         <= high_nibble_next;
        bytes_done          <= bytes_done_next;
        colon_allowed       <= colon_allowed_next;
        address_accumulator <= address_accumulator_next;
        error_seen          <= error_seen_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && s1_eos;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && s1_eos) begin
      mac_address <= result_ok ? address_accumulator_next : '0;
      status      <= !result_ok;
    end
  end

  // checks

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    bytes_done <= matp_pkg::BYTES_FULL)
    else $error("completed byte count past address length");

  a_error_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> mac_address == '0)
    else $error("malformed result carries a nonzero address");

  a_colon_after_byte: assert property (@(posedge clk) disable iff (rst)
    expect_low_nibble |-> !colon_allowed)
    else $error("colon allowed in the middle of a byte");

  a_held_char_stays: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_char) && $stable(s1_eos))
    else $error("waiting character lost from the input register");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_eos |=> bytes_done == '0 && !error_seen && !expect_low_nibble)
    else $error("parser not back at start after a string");

endmodule

`default_nettype wire
